// File: rtl/pfm_pkg.sv
// Package: shared types and codes for the PCM-to-mono converter.
`timescale 1ns / 1ps

package pfm_pkg;

	// Sample format codes (sample_format register)
	typedef enum logic [2:0] {
		FMT_PCM16 = 3'd0,
		FMT_PCM8  = 3'd1,
		FMT_ALAW  = 3'd2,
		FMT_ULAW  = 3'd3,
		FMT_FLT32 = 3'd4,
		FMT_PCM24 = 3'd5
	} fmt_t;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

	// Field widths
	localparam int WORD_W = 32;
	localparam int SMP_W  = 24;
	localparam int CNT_W  = 4;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_START,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: rtl/pfm_convert.sv
// Sample word decoder: one raw word of any supported format to signed Q1.23.
`timescale 1ns / 1ps

module pfm_convert (
	input  pfm_pkg::fmt_t                      sample_format,
	input  logic [pfm_pkg::WORD_W-1:0]         word,
	output logic signed [pfm_pkg::SMP_W-1:0]   sample
);

	logic [7:0]         mu_inv;
	logic [15:0]        mu_base;
	logic [15:0]        mu_mag;
	logic [15:0]        mu_val;
	logic [7:0]         a_x;
	logic [15:0]        a_t0;
	logic [15:0]        a_mag;
	logic [15:0]        a_val;
	logic [7:0]         f_exp;
	logic [22:0]        f_man;
	logic [4:0]         f_sh;
	logic [23:0]        f_mag;
	logic signed [23:0] f_val;

	// G.711 mu-law
	always_comb begin
		mu_inv  = ~word[7:0];
		mu_base = {9'd0, mu_inv[3:0], 3'd0} + 16'h0084;
		mu_mag  = (mu_base << mu_inv[6:4]) - 16'h0084;
		mu_val  = mu_inv[7] ? (16'd0 - mu_mag) : mu_mag;
	end

	// G.711 A-law, sign bit set means positive
	always_comb begin
		a_x  = word[7:0] ^ 8'h55;
		a_t0 = {8'd0, a_x[3:0], 4'd0};
		if (a_x[6:4] == 3'd0) begin
			a_mag = a_t0 + 16'd8;
		end else begin
			a_mag = (a_t0 + 16'h0108) << (a_x[6:4] - 3'd1);
		end
		a_val = a_x[7] ? a_mag : (16'd0 - a_mag);
	end

	// float32: truncate toward zero, saturate at |x| >= 1, NaN to zero
	always_comb begin
		f_exp = word[30:23];
		f_man = word[22:0];
		f_sh  = 5'(8'd127 - f_exp);
		f_mag = {1'b1, f_man} >> f_sh;
		if (f_exp == 8'hFF && f_man != 23'd0) begin
			f_val = '0;
		end else if (f_exp >= 8'd127) begin
			f_val = word[31] ? 24'sh800000 : 24'sh7FFFFF;
		end else if (f_exp <= 8'd103) begin
			f_val = '0;   // zero, denormals and values below one LSB
		end else begin
			f_val = word[31] ? $signed(24'd0 - f_mag) : $signed(f_mag);
		end
	end

	always_comb begin
		unique case (sample_format)
			pfm_pkg::FMT_PCM16: sample = $signed({word[15:0], 8'd0});
			pfm_pkg::FMT_PCM8:  sample = $signed({~word[7], word[6:0], 16'd0});
			pfm_pkg::FMT_ALAW:  sample = $signed({a_val, 8'd0});
			pfm_pkg::FMT_ULAW:  sample = $signed({mu_val, 8'd0});
			pfm_pkg::FMT_FLT32: sample = f_val;
			pfm_pkg::FMT_PCM24: sample = $signed(word[23:0]);
			default:            sample = '0;
		endcase
	end

endmodule

// File: rtl/pfm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module pfm_div #(
	parameter int DVD_W = 27,
	parameter int DVS_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DVD_W-1:0]           dividend,
	input  logic [DVS_W-1:0]           divisor,
	output logic [DVD_W-1:0]           quotient,
	output pfm_pkg::div_status_t       status
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   r_shift;
	logic [DVS_W+1:0] trial;
	logic             qbit;

	always_comb begin
		r_shift = {rem_q, dvd_q[DVD_W-1]};
		trial   = {1'b0, r_shift} - {2'b00, dvs_q};
		qbit    = ~trial[DVS_W+1];
	end

	// Quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? trial[DVS_W-1:0] : r_shift[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DVD_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with an exhausted step count");

endmodule

// File: rtl/pcm_format_to_mono_fixed_unit.sv
// Top level: multi-format PCM/G.711/float32 to Q1.23 converter with channel downmix.
`timescale 1ns / 1ps

// Each word on the input stream is one channel sample in the format chosen by
// sample_format (pcm16, offset pcm8, A-law, mu-law, float32, pcm24). It is
// decoded to signed Q1.23 and added to a frame sum; after channel_count words
// (0 counts as 1, values above MAX_CHANNELS clip to MAX_CHANNELS) the frame
// average, truncated toward zero, leaves on the output stream as one mono
// sample. A word that does not close a frame is accepted, then decoded and
// accumulated. The word that closes a frame is accepted, accumulated and then
// averaged by the divide, a restoring divider producing one quotient bit per
// cycle over the full sum width. s_axis_tready is low from the accumulate
// step until the finish step is done. The result sits in an output
// register, so the next frame may start while a finished sample waits for the
// consumer; if the previous sample is still not taken when the divide ends, the
// finish step holds (tready stays low) until the output register frees. Writing
// register 0 or 1 drops any partial frame; configuration is only to be written
// when no transaction is in flight.

module pcm_format_to_mono_fixed_unit #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // [31:0] sample_word
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata   // [23:0] mono_sample
);

	// frame sum grows by clog2 of the channel count
	localparam int SUM_W = pfm_pkg::SMP_W + $clog2(MAX_CHANNELS);
	// channel counter and divisor width, holds MAX_CHANNELS itself
	localparam int N_W   = $clog2(MAX_CHANNELS + 1);
	localparam logic [4:0] MAX5 = 5'(MAX_CHANNELS);
	localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'(8388607);
	localparam logic signed [SUM_W:0] SAT_LO = -(SUM_W+1)'(8388608);

	pfm_pkg::state_t      state_q, state_d;
	pfm_pkg::fmt_t        fmt_q;
	logic [pfm_pkg::CNT_W-1:0] cnt_cfg_q;
	logic [31:0]          word_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [N_W-1:0]       idx_q;
	logic [N_W-1:0]       idx_inc;
	logic [N_W-1:0]       n_w;
	logic [4:0]           n5;
	logic                 frame_end;
	logic                 cfg_clear;
	logic signed [pfm_pkg::SMP_W-1:0] conv;
	logic [SUM_W-1:0]     sum_mag;
	logic [SUM_W-1:0]     quot;
	logic signed [SUM_W:0] avg;
	logic [23:0]          avg_sat;
	logic                 div_start;
	logic                 load_out;
	logic                 out_free;
	pfm_pkg::div_status_t div_st;
	logic                 out_valid_q;
	logic [23:0]          out_data_q;

	assign cfg_ready = 1'b1;

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= pfm_pkg::FMT_PCM16;
			cnt_cfg_q <= pfm_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pfm_pkg::REG_SAMPLE_FORMAT: fmt_q <= pfm_pkg::fmt_t'(cfg_data[2:0]);
				pfm_pkg::REG_CHANNEL_COUNT: cnt_cfg_q <= cfg_data[pfm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_clear = cfg_valid && cfg_ready &&
			(cfg_index == pfm_pkg::REG_SAMPLE_FORMAT ||
			 cfg_index == pfm_pkg::REG_CHANNEL_COUNT);
	end

	// effective channel count: zero means one, clip at MAX_CHANNELS
	always_comb begin
		if (cnt_cfg_q == '0) begin
			n5 = 5'd1;
		end else if ({1'b0, cnt_cfg_q} > MAX5) begin
			n5 = MAX5;
		end else begin
			n5 = {1'b0, cnt_cfg_q};
		end
		n_w = N_W'(n5);
	end

	// ---- decode ----
	pfm_convert u_convert (
		.sample_format (fmt_q),
		.word          (word_q),
		.sample        (conv)
	);

	assign idx_inc   = idx_q + 1'b1;
	assign frame_end = (idx_inc >= n_w);
	assign sum_mag   = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;

	// ---- shared divider ----
	pfm_div #(
		.DVD_W (SUM_W),
		.DVS_W (N_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (n_w),
		.quotient (quot),
		.status   (div_st)
	);

	// signed average, clamped to Q1.23
	always_comb begin
		avg = sum_q[SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		if (avg > SAT_HI) begin
			avg_sat = 24'h7FFFFF;
		end else if (avg < SAT_LO) begin
			avg_sat = 24'h800000;
		end else begin
			avg_sat = avg[23:0];
		end
	end

	// ---- sequencer ----
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfm_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = pfm_pkg::ST_ACCUM;
			pfm_pkg::ST_ACCUM:  state_d = frame_end ? pfm_pkg::ST_START : pfm_pkg::ST_IDLE;
			pfm_pkg::ST_START:  state_d = pfm_pkg::ST_DIVIDE;
			pfm_pkg::ST_DIVIDE: if (div_st.done) state_d = pfm_pkg::ST_FINISH;
			pfm_pkg::ST_FINISH: if (out_free) state_d = pfm_pkg::ST_IDLE;
			default:            state_d = pfm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == pfm_pkg::ST_IDLE);
		div_start     = (state_q == pfm_pkg::ST_START);
		load_out      = (state_q == pfm_pkg::ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_q <= s_axis_tdata;
		end
	end

	// frame sum and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (cfg_clear || load_out) begin
			sum_q <= '0;
			idx_q <= '0;
		end else if (state_q == pfm_pkg::ST_ACCUM) begin
			sum_q <= sum_q + SUM_W'(conv);
			idx_q <= idx_inc;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= avg_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfm_pkg::ST_IDLE) |-> (idx_q < n_w))
		else $error("channel index reached frame size while idle");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		(div_st.busy || div_st.done) |-> (state_q == pfm_pkg::ST_DIVIDE))
		else $error("divider active outside the divide state");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (m_axis_tvalid && idx_q == '0))
		else $error("finished frame not presented or counter not cleared");

	a_no_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfm_pkg::ST_ACCUM && !frame_end && !out_valid_q) |=> !m_axis_tvalid)
		else $error("result produced mid-frame");

endmodule

// File: bench/pcm_format_to_mono_fixed_unit_test.sv
// Testbench for pcm_format_to_mono_fixed_unit: random streams checked against a built-in predictor.
`timescale 1ns / 1ps

module pcm_format_to_mono_fixed_unit_test;

	localparam int MAX_CH       = 8;
	localparam int RANDOM_WORDS = 1950;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int FAULT_SHOWN  = 10;

	// register index with no register behind it; a write must change nothing
	localparam logic [pfm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// format codes with no decoder behind them; the wide one only aliases in its low bits
	localparam logic [3:0] FMT_SPARE      = 4'd7;
	localparam logic [3:0] FMT_SPARE_WIDE = 4'd14;

	// bias of the word generator toward full-scale values
	localparam int BIAS_NONE = 0;
	localparam int BIAS_MAX  = 1;
	localparam int BIAS_MIN  = 2;

	// idling modes for sender and receiver
	localparam int FLOW_STEADY = 0;
	localparam int FLOW_RANDOM = 1;
	localparam int FLOW_RUNS   = 2;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pfm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [31:0]                    s_axis_tdata = '0;  // [31:0] sample_word
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [23:0]                    m_axis_tdata;       // [23:0] mono_sample

	pcm_format_to_mono_fixed_unit #(
		.MAX_CHANNELS(MAX_CH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// words waiting for the driver, and mono samples the block still owes us
	logic [31:0]        word_queue[$];
	logic signed [23:0] expected_mono[$];

	// predictor copy of the registers and the frame accumulator
	logic [2:0]         cur_format = pfm_pkg::FMT_PCM16;
	logic [3:0]         cur_channels = 4'd1;
	logic signed [26:0] frame_sum = '0;
	int                 frame_fill = 0;

	int send_mode = FLOW_STEADY;
	int recv_mode = FLOW_STEADY;
	int fault_count = 0;
	int cycle_count = 0;
	int sent_total = 0;

	// ------------------------------------------------------------------
	// Sample decode to Q1.23
	// ------------------------------------------------------------------
	function automatic int decode_q23(input logic [2:0] fmt, input logic [31:0] w);
		logic [7:0]  code;
		logic [7:0]  expo;
		logic [23:0] mant;
		int          t;
		case (fmt)
			pfm_pkg::FMT_PCM16: return int'($signed(w[15:0])) * 256;
			pfm_pkg::FMT_PCM8:  return (int'(w[7:0]) - 128) * 65536;
			pfm_pkg::FMT_ALAW: begin
				code = w[7:0] ^ 8'h55;
				t = int'(code[3:0]) * 16;
				if (code[6:4] == 3'd0)
					t = t + 8;
				else
					t = (t + 264) << (code[6:4] - 3'd1);
				return (code[7] ? t : -t) * 256;
			end
			pfm_pkg::FMT_ULAW: begin
				code = ~w[7:0];
				t = ((int'(code[3:0]) * 8 + 132) << code[6:4]) - 132;
				return (code[7] ? -t : t) * 256;
			end
			pfm_pkg::FMT_FLT32: begin
				expo = w[30:23];
				// NaN first, then magnitude >= 1.0 (and infinity) saturates
				if (expo == 8'hFF && w[22:0] != '0)
					return 0;
				if (expo >= 8'd127)
					return w[31] ? -8388608 : 8388607;
				if (expo == 8'd0 || (127 - int'(expo)) >= 24)
					return 0;
				mant = {1'b1, w[22:0]} >> (127 - int'(expo));
				return w[31] ? -int'(mant) : int'(mant);
			end
			pfm_pkg::FMT_PCM24: return int'($signed(w[23:0]));
			default:   return 0;
		endcase
	endfunction

	// accept one channel word; on the last channel queue the truncated average
	task automatic absorb_word(input logic [31:0] w);
		int n;
		int avg;
		n = (cur_channels == 4'd0) ? 1 : int'(cur_channels);
		if (n > MAX_CH)
			n = MAX_CH;
		frame_sum = frame_sum + 27'(decode_q23(cur_format, w));
		frame_fill++;
		if (frame_fill >= n) begin
			avg = int'(frame_sum) / n;  // SV int divide truncates toward zero
			if (avg > 8388607)
				avg = 8388607;
			if (avg < -8388608)
				avg = -8388608;
			expected_mono.push_back(avg[23:0]);
			frame_sum = '0;
			frame_fill = 0;
		end
	endtask

	task automatic note_fault(input string what, input logic [23:0] want, input logic [23:0] got);
		fault_count++;
		if (fault_count <= FAULT_SHOWN)
			$display("ERROR @%0t: %s expected %0d actual %0d", $realtime, what,
				$signed(want), $signed(got));
	endtask

	// ------------------------------------------------------------------
	// Driver: steady, with random gaps, or in bursts of random length with random gaps between
	// ------------------------------------------------------------------
	int gap_left = 0;
	int burst_left = 1;

	always @(posedge clk) begin : drive_words
		logic        nv;
		logic [31:0] nd;
		nv = s_axis_tvalid;
		nd = s_axis_tdata;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (word_queue.size() > 0) begin
				nd = word_queue.pop_front();
				nv = 1'b1;
				if (send_mode == FLOW_RANDOM) begin
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
				end else if (send_mode == FLOW_RUNS) begin
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left = $urandom_range(1, 12);
					end
				end
			end
		end
		s_axis_tvalid <= nv;
		s_axis_tdata <= nd;
	end

	// ------------------------------------------------------------------
	// Receiver backpressure
	// ------------------------------------------------------------------
	int  run_left = 0;
	logic run_stall = 1'b0;

	always @(posedge clk) begin : drive_ready
		logic nr;
		nr = 1'b1;
		if (!arst_n) begin
			nr = 1'b0;
		end else if (recv_mode == FLOW_RANDOM) begin
			nr = ($urandom_range(0, 3) != 0);
		end else if (recv_mode == FLOW_RUNS) begin
			if (run_left > 0) begin
				run_left--;
			end else begin
				run_stall = !run_stall;
				run_left = run_stall ? $urandom_range(1, 40) : $urandom_range(1, 12);
			end
			nr = !run_stall;
		end
		m_axis_tready <= nr;
	end

	// ------------------------------------------------------------------
	// Monitor: predict on accepted words, check accepted mono samples
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_streams
		logic signed [23:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_word(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_mono.size() == 0) begin
					note_fault("unexpected mono sample,", '0, m_axis_tdata);
				end else begin
					want = expected_mono.pop_front();
					if (m_axis_tdata !== want)
						note_fault("mono_sample mismatch,", want, m_axis_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------

	// everything sent, every sample back, plus room for a frame still in work
	task automatic wait_drained();
		@(negedge clk);
		while (word_queue.size() != 0 || s_axis_tvalid || expected_mono.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pfm_pkg::CFG_IDX_W-1:0] idx,
			input logic [pfm_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		// both real registers drop the partial frame
		case (idx)
			pfm_pkg::REG_SAMPLE_FORMAT: begin
				cur_format = val[2:0];
				frame_sum = '0;
				frame_fill = 0;
			end
			pfm_pkg::REG_CHANNEL_COUNT: begin
				cur_channels = val;
				frame_sum = '0;
				frame_fill = 0;
			end
			default: ;
		endcase
	endtask

	task automatic start_phase(input logic [3:0] fmt_val, input logic [3:0] cnt_val);
		wait_drained();
		if ($urandom_range(0, 1) == 0) begin
			write_reg(pfm_pkg::REG_SAMPLE_FORMAT, fmt_val);
			write_reg(pfm_pkg::REG_CHANNEL_COUNT, cnt_val);
		end else begin
			write_reg(pfm_pkg::REG_CHANNEL_COUNT, cnt_val);
			write_reg(pfm_pkg::REG_SAMPLE_FORMAT, fmt_val);
		end
		send_mode = $urandom_range(FLOW_STEADY, FLOW_RUNS);
		recv_mode = $urandom_range(FLOW_STEADY, FLOW_RUNS);
		@(negedge clk);
	endtask

	// random word with a share of full-scale and format-specific corner values
	function automatic logic [31:0] random_word(input logic [2:0] fmt, input int bias);
		logic [31:0] w;
		int          pick;
		w = $urandom();
		pick = $urandom_range(0, 9);
		if (bias != BIAS_NONE && $urandom_range(0, 3) != 0)
			pick = (bias == BIAS_MAX) ? 0 : 1;
		case (fmt)
			pfm_pkg::FMT_PCM16: begin
				if (pick == 0) w[15:0] = 16'h7FFF;
				if (pick == 1) w[15:0] = 16'h8000;
			end
			pfm_pkg::FMT_PCM8: begin
				if (pick == 0) w[7:0] = 8'hFF;
				if (pick == 1) w[7:0] = 8'h00;
			end
			pfm_pkg::FMT_ALAW: begin
				if (pick == 0) w[7:0] = 8'hAA;
				if (pick == 1) w[7:0] = 8'h2A;
				if (pick == 2) w[7:0] = 8'h55;
				if (pick == 3) w[7:0] = 8'hD5;
			end
			pfm_pkg::FMT_ULAW: begin
				if (pick == 0) w[7:0] = 8'h80;
				if (pick == 1) w[7:0] = 8'h00;
				if (pick == 2) w[7:0] = 8'hFF;
				if (pick == 3) w[7:0] = 8'h7F;
			end
			pfm_pkg::FMT_FLT32: begin
				case (pick)
					0, 1: begin
						w[31] = (pick == 1);
						w[30:23] = 8'($urandom_range(127, 254));
					end
					2: begin
						w[30:23] = 8'hFF;       // NaN, or infinity when mantissa cleared
						if ($urandom_range(0, 1) == 0)
							w[22:0] = '0;
					end
					3: w[30:23] = 8'h00;        // zero and denormals
					4: w[30:23] = 8'($urandom_range(1, 103));
					default: w[30:23] = 8'($urandom_range(104, 126));
				endcase
			end
			pfm_pkg::FMT_PCM24: begin
				if (pick == 0) w[23:0] = 24'h7FFFFF;
				if (pick == 1) w[23:0] = 24'h800000;
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic run_random_phase(input logic [3:0] fmt_val, input logic [3:0] cnt_val,
			input int bias);
		int count;
		start_phase(fmt_val, cnt_val);
		count = $urandom_range(30, 120);
		repeat (count)
			word_queue.push_back(random_word(fmt_val[2:0], bias));
		sent_total += count;
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [3:0] fv;
		logic [3:0] cv;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: pcm16, one channel; upper word bits must be ignored
		word_queue.push_back(32'h0000_7FFF);
		word_queue.push_back(32'hFFFF_8000);
		word_queue.push_back(32'h1234_0001);

		start_phase({1'b0, pfm_pkg::FMT_PCM8}, 4'd1);
		word_queue.push_back(32'hFFFF_FF00);
		word_queue.push_back(32'h0000_00FF);
		word_queue.push_back(32'h0000_0080);

		// A-law: code 0x00 decodes to -5504, 0xD5 is the smallest positive step
		start_phase({1'b0, pfm_pkg::FMT_ALAW}, 4'd1);
		word_queue.push_back(32'h0000_0000);
		word_queue.push_back(32'h0000_00D5);
		word_queue.push_back(32'hFFFF_FF2A);

		// mu-law: 0x00 decodes to -32124
		start_phase({1'b0, pfm_pkg::FMT_ULAW}, 4'd1);
		word_queue.push_back(32'h0000_0000);
		word_queue.push_back(32'h0000_0080);
		word_queue.push_back(32'h0000_00FF);

		// float: +/-1.0 saturate, NaN, -inf, denormal, -0.5, value below one LSB
		start_phase({1'b0, pfm_pkg::FMT_FLT32}, 4'd1);
		word_queue.push_back(32'h3F80_0000);
		word_queue.push_back(32'hBF80_0000);
		word_queue.push_back(32'h7FC0_0000);
		word_queue.push_back(32'hFF80_0000);
		word_queue.push_back(32'h0000_0001);
		word_queue.push_back(32'hBF00_0000);
		word_queue.push_back(32'h33FF_FFFF);

		// pcm24 over three channels: sum -2 averages to 0 (truncation toward zero)
		start_phase({1'b0, pfm_pkg::FMT_PCM24}, 4'd3);
		write_reg(REG_UNUSED, 4'hF);
		@(negedge clk);
		word_queue.push_back(32'h00FF_FFFF);
		word_queue.push_back(32'hAAFF_FFFF);
		word_queue.push_back(32'h0000_0000);

		// unused format code contributes 0; channel count 0 acts as 1
		start_phase(FMT_SPARE, 4'd0);
		word_queue.push_back(32'hFFFF_FFFF);

		// corner settings first, then random ones; phases may end mid-frame
		run_random_phase({1'b0, pfm_pkg::FMT_PCM24}, 4'd8, BIAS_MAX);
		run_random_phase({1'b0, pfm_pkg::FMT_PCM8}, 4'd8, BIAS_MIN);
		run_random_phase({1'b0, pfm_pkg::FMT_PCM16}, 4'd15, BIAS_MIN);
		run_random_phase({1'b0, pfm_pkg::FMT_FLT32}, 4'd8, BIAS_MAX);
		run_random_phase(FMT_SPARE_WIDE, 4'd9, BIAS_NONE);
		run_random_phase({1'b1, pfm_pkg::FMT_ALAW}, 4'd2, BIAS_NONE);
		run_random_phase({1'b0, pfm_pkg::FMT_ULAW}, 4'd5, BIAS_NONE);
		run_random_phase({1'b0, pfm_pkg::FMT_FLT32}, 4'd1, BIAS_NONE);
		while (sent_total < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) < 8)
				fv = 4'($urandom_range(0, 5));
			else
				fv = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 9) < 8)
				cv = 4'($urandom_range(1, 8));
			else
				cv = 4'($urandom_range(0, 15));
			run_random_phase(fv, cv, BIAS_NONE);
		end

		wait_drained();
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/pfm_pkg.sv
rtl/pfm_convert.sv
rtl/pfm_div.sv
rtl/pcm_format_to_mono_fixed_unit.sv
bench/pcm_format_to_mono_fixed_unit_test.sv
